FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of aclk while out of reset.
`define QRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition implies another on the same edge.
`define QRR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/qrr_pkg.sv
`default_nettype none
package qrr_pkg;

    localparam int IN_W         = 16;
    localparam int OUT_W        = 16;
    localparam int PROD1_W      = 32;
    localparam int R_W          = 34;
    localparam int MAG_W        = 33;
    localparam int RED_W        = 21;
    localparam int RED_MAG_W    = 20;
    localparam int SHIFT_W      = 4;
    localparam int PROD2_W      = 42;
    localparam int NUM_W        = 44;
    localparam int N_W          = 43;
    localparam int DEN_W        = 44;
    localparam int REM_W        = 58;
    localparam int Q_W          = 15;
    localparam int LANES        = 9;
    localparam int FRONT_STAGES = 7;
    localparam int DIV_STEPS    = Q_W;
    localparam int STAGES       = FRONT_STAGES + DIV_STEPS + 1;
    localparam int DIAG_SHIFT   = 14;
    localparam int OFF_SHIFT    = 15;
    localparam int ONE_Q14      = 16384;

    localparam logic [LANES-1:0] DIAG_LANES = 9'b100010001;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic [LANES-1:0]      neg;
        logic [DEN_W-1:0]      den;
        logic                  degen;
    } div_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/qrr_front.sv
`default_nettype none
module qrr_front
    import qrr_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic [FRONT_STAGES-1:0]        en,
    input  wire logic signed [IN_W-1:0]         aw,
    input  wire logic signed [IN_W-1:0]         ax,
    input  wire logic signed [IN_W-1:0]         ay,
    input  wire logic signed [IN_W-1:0]         az,
    input  wire logic signed [IN_W-1:0]         bw,
    input  wire logic signed [IN_W-1:0]         bx,
    input  wire logic signed [IN_W-1:0]         by,
    input  wire logic signed [IN_W-1:0]         bz,
    output div_word_t                           word
);

    logic signed [PROD1_W-1:0] pww_reg, pxx_reg, pyy_reg, pzz_reg;
    logic signed [PROD1_W-1:0] pwx_reg, pxw_reg, pyz_reg, pzy_reg;
    logic signed [PROD1_W-1:0] pwy_reg, pyw_reg, pzx_reg, pxz_reg;
    logic signed [PROD1_W-1:0] pwz_reg, pzw_reg, pxy_reg, pyx_reg;
    logic signed [R_W-1:0]     r_reg [4];
    logic [MAG_W-1:0]          mag_reg [4];
    logic [3:0]                rneg_reg;
    logic [MAG_W-1:0]          mag_or;
    logic [SHIFT_W-1:0]        k;
    logic signed [RED_W-1:0]   red_next [4];
    logic signed [RED_W-1:0]   red_reg [4];
    logic signed [PROD2_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD2_W-1:0] xy_reg, xz_reg, yz_reg, xw_reg, yw_reg, zw_reg;
    logic signed [NUM_W-1:0]   sum_next [LANES];
    logic signed [NUM_W-1:0]   sum_reg [LANES];
    logic [N_W-1:0]            n_next;
    logic [N_W-1:0]            n_reg;
    div_word_t                 word_next;
    div_word_t                 word_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pww_reg <= PROD1_W'(aw) * PROD1_W'(bw);
            pxx_reg <= PROD1_W'(ax) * PROD1_W'(bx);
            pyy_reg <= PROD1_W'(ay) * PROD1_W'(by);
            pzz_reg <= PROD1_W'(az) * PROD1_W'(bz);
            pwx_reg <= PROD1_W'(aw) * PROD1_W'(bx);
            pxw_reg <= PROD1_W'(ax) * PROD1_W'(bw);
            pyz_reg <= PROD1_W'(ay) * PROD1_W'(bz);
            pzy_reg <= PROD1_W'(az) * PROD1_W'(by);
            pwy_reg <= PROD1_W'(aw) * PROD1_W'(by);
            pyw_reg <= PROD1_W'(ay) * PROD1_W'(bw);
            pzx_reg <= PROD1_W'(az) * PROD1_W'(bx);
            pxz_reg <= PROD1_W'(ax) * PROD1_W'(bz);
            pwz_reg <= PROD1_W'(aw) * PROD1_W'(bz);
            pzw_reg <= PROD1_W'(az) * PROD1_W'(bw);
            pxy_reg <= PROD1_W'(ax) * PROD1_W'(by);
            pyx_reg <= PROD1_W'(ay) * PROD1_W'(bx);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            r_reg[0] <= R_W'(pww_reg) + R_W'(pxx_reg) + R_W'(pyy_reg) + R_W'(pzz_reg);
            r_reg[1] <= R_W'(pwx_reg) - R_W'(pxw_reg) - R_W'(pyz_reg) + R_W'(pzy_reg);
            r_reg[2] <= R_W'(pwy_reg) - R_W'(pyw_reg) - R_W'(pzx_reg) + R_W'(pxz_reg);
            r_reg[3] <= R_W'(pwz_reg) - R_W'(pzw_reg) - R_W'(pxy_reg) + R_W'(pyx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 4; i++) begin
                rneg_reg[i] <= r_reg[i][R_W-1];
                mag_reg[i]  <= r_reg[i][R_W-1] ? MAG_W'(-r_reg[i]) : MAG_W'(r_reg[i]);
            end
        end
    end

    // The shift that brings the largest component below 2^20 follows from
    // the leading one of all four magnitudes ored together.
    always_comb begin
        logic [MAG_W-1:0] sh;
        mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
        k = '0;
        for (int b = RED_MAG_W; b < MAG_W; b++) begin
            if (mag_or[b]) begin
                k = SHIFT_W'(b - RED_MAG_W + 1);
            end
        end
        for (int i = 0; i < 4; i++) begin
            sh = mag_reg[i] >> k;
            red_next[i] = rneg_reg[i] ? -RED_W'(sh[RED_MAG_W-1:0])
                                      : RED_W'(sh[RED_MAG_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < 4; i++) begin
                red_reg[i] <= red_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            ww_reg <= PROD2_W'(red_reg[0]) * PROD2_W'(red_reg[0]);
            xx_reg <= PROD2_W'(red_reg[1]) * PROD2_W'(red_reg[1]);
            yy_reg <= PROD2_W'(red_reg[2]) * PROD2_W'(red_reg[2]);
            zz_reg <= PROD2_W'(red_reg[3]) * PROD2_W'(red_reg[3]);
            xy_reg <= PROD2_W'(red_reg[1]) * PROD2_W'(red_reg[2]);
            xz_reg <= PROD2_W'(red_reg[1]) * PROD2_W'(red_reg[3]);
            yz_reg <= PROD2_W'(red_reg[2]) * PROD2_W'(red_reg[3]);
            xw_reg <= PROD2_W'(red_reg[1]) * PROD2_W'(red_reg[0]);
            yw_reg <= PROD2_W'(red_reg[2]) * PROD2_W'(red_reg[0]);
            zw_reg <= PROD2_W'(red_reg[3]) * PROD2_W'(red_reg[0]);
        end
    end

    always_comb begin
        n_next = N_W'($unsigned(ww_reg)) + N_W'($unsigned(xx_reg))
               + N_W'($unsigned(yy_reg)) + N_W'($unsigned(zz_reg));
        sum_next[0] = NUM_W'(ww_reg) + NUM_W'(xx_reg) - NUM_W'(yy_reg) - NUM_W'(zz_reg);
        sum_next[1] = NUM_W'(xy_reg) - NUM_W'(zw_reg);
        sum_next[2] = NUM_W'(xz_reg) + NUM_W'(yw_reg);
        sum_next[3] = NUM_W'(xy_reg) + NUM_W'(zw_reg);
        sum_next[4] = NUM_W'(ww_reg) - NUM_W'(xx_reg) + NUM_W'(yy_reg) - NUM_W'(zz_reg);
        sum_next[5] = NUM_W'(yz_reg) - NUM_W'(xw_reg);
        sum_next[6] = NUM_W'(xz_reg) - NUM_W'(yw_reg);
        sum_next[7] = NUM_W'(yz_reg) + NUM_W'(xw_reg);
        sum_next[8] = NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(yy_reg) + NUM_W'(zz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            n_reg <= n_next;
            for (int l = 0; l < LANES; l++) begin
                sum_reg[l] <= sum_next[l];
            end
        end
    end

    // Rounding to nearest is folded into the dividend: (2a + n) / (2n).
    always_comb begin
        logic [NUM_W-1:0] mag;
        logic [REM_W-1:0] num;
        word_next.den   = DEN_W'(n_reg) << 1;
        word_next.degen = (n_reg == '0);
        for (int l = 0; l < LANES; l++) begin
            mag = sum_reg[l][NUM_W-1] ? NUM_W'(-sum_reg[l]) : NUM_W'(sum_reg[l]);
            num = DIAG_LANES[l] ? (REM_W'(mag) << DIAG_SHIFT) : (REM_W'(mag) << OFF_SHIFT);
            word_next.neg[l]      = sum_reg[l][NUM_W-1];
            word_next.lane[l].rem = (num << 1) + REM_W'(n_reg);
            word_next.lane[l].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule
`default_nettype wire

FILE: rtl/core/qrr_div_step.sv
`default_nettype none
module qrr_div_step
    import qrr_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire div_word_t word_in,
    output div_word_t      word_out
);

    div_word_t word_next;
    div_word_t word_reg;

    always_comb begin
        logic [REM_W-1:0] dsh;
        logic [REM_W:0]   diff;
        word_next = word_in;
        dsh = REM_W'(word_in.den) << SHIFT;
        for (int l = 0; l < LANES; l++) begin
            diff = {1'b0, word_in.lane[l].rem} - {1'b0, dsh};
            if (!diff[REM_W]) begin
                word_next.lane[l].rem = diff[REM_W-1:0];
                word_next.lane[l].quo = {word_in.lane[l].quo[Q_W-2:0], 1'b1};
            end else begin
                word_next.lane[l].quo = {word_in.lane[l].quo[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule
`default_nettype wire

FILE: rtl/core/quaternion_relative_rotation_matrix_top.sv
// Relative rotation of two orientation quaternions as a 3x3 matrix in Q2.14.
// Input channel: s_valid/s_ready with the own quaternion s_self_* and the
// other quaternion s_peer_*, all signed Q2.14. Each accepted word yields one
// output word on m_valid/m_ready: nine matrix entries m_m00..m_m22 clamped to
// plus or minus one, and m_degenerate, which is set with an all-zero matrix
// when either quaternion is zero.
// The pipeline has 23 register stages: seven stages of products, sums,
// range reduction and numerators, fifteen stages of a one-bit-per-stage
// restoring divider, and one stage of sign restoration and clamping into
// the output register.
// Throughput is one word per cycle while m_ready is high. Every stage has
// its own valid bit and advances when it is empty or its successor
// advances, so bubbles close up and new words are taken while a finished
// word waits at the output. When the receiver holds m_ready low the
// pipeline fills up and s_ready falls only once every stage holds a word;
// nothing is lost or repeated. Reset clears only the valid bits.
`default_nettype none
module quaternion_relative_rotation_matrix_top
    import qrr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_self_w,
    input  wire logic signed [IN_W-1:0]  s_self_x,
    input  wire logic signed [IN_W-1:0]  s_self_y,
    input  wire logic signed [IN_W-1:0]  s_self_z,
    input  wire logic signed [IN_W-1:0]  s_peer_w,
    input  wire logic signed [IN_W-1:0]  s_peer_x,
    input  wire logic signed [IN_W-1:0]  s_peer_y,
    input  wire logic signed [IN_W-1:0]  s_peer_z,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_m00,
    output logic signed [OUT_W-1:0]      m_m01,
    output logic signed [OUT_W-1:0]      m_m02,
    output logic signed [OUT_W-1:0]      m_m10,
    output logic signed [OUT_W-1:0]      m_m11,
    output logic signed [OUT_W-1:0]      m_m12,
    output logic signed [OUT_W-1:0]      m_m20,
    output logic signed [OUT_W-1:0]      m_m21,
    output logic signed [OUT_W-1:0]      m_m22,
    output logic                         m_degenerate
);

`include "assert_macros.svh"

    logic [STAGES-1:0]       v_reg;
    logic [STAGES-1:0]       v_next;
    logic [STAGES-1:0]       en;
    div_word_t               word [DIV_STEPS+1];
    logic signed [OUT_W-1:0] res_next [LANES];
    logic signed [OUT_W-1:0] res_reg [LANES];
    logic                    degen_reg;

    always_comb begin
        en[STAGES-1] = !v_reg[STAGES-1] || m_ready;
        for (int i = STAGES-2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];

    qrr_front u_front (
        .aclk (aclk),
        .en   (en[FRONT_STAGES-1:0]),
        .aw   (s_self_w),
        .ax   (s_self_x),
        .ay   (s_self_y),
        .az   (s_self_z),
        .bw   (s_peer_w),
        .bx   (s_peer_x),
        .by   (s_peer_y),
        .bz   (s_peer_z),
        .word (word[0])
    );

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        qrr_div_step #(
            .SHIFT (DIV_STEPS - 1 - j)
        ) u_step (
            .aclk     (aclk),
            .en       (en[FRONT_STAGES + j]),
            .word_in  (word[j]),
            .word_out (word[j+1])
        );
    end

    always_comb begin
        logic [Q_W-1:0]   q;
        logic [OUT_W-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            q = word[DIV_STEPS].lane[l].quo;
            if (q > Q_W'(ONE_Q14)) begin
                q = Q_W'(ONE_Q14);
            end
            mag = OUT_W'(q);
            if (word[DIV_STEPS].degen) begin
                res_next[l] = '0;
            end else if (word[DIV_STEPS].neg[l]) begin
                res_next[l] = -$signed(mag);
            end else begin
                res_next[l] = $signed(mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[STAGES-1]) begin
            degen_reg <= word[DIV_STEPS].degen;
            for (int l = 0; l < LANES; l++) begin
                res_reg[l] <= res_next[l];
            end
        end
    end

    assign m_valid      = v_reg[STAGES-1];
    assign m_degenerate = degen_reg;
    assign m_m00        = res_reg[0];
    assign m_m01        = res_reg[1];
    assign m_m02        = res_reg[2];
    assign m_m10        = res_reg[3];
    assign m_m11        = res_reg[4];
    assign m_m12        = res_reg[5];
    assign m_m20        = res_reg[6];
    assign m_m21        = res_reg[7];
    assign m_m22        = res_reg[8];

    `QRR_ASSERT_IMPLY(a_degen_zero, m_valid && m_degenerate,
        m_m00 == 0 && m_m11 == 0 && m_m22 == 0 && m_m01 == 0, "degenerate word not zeroed")
    `QRR_ASSERT_IMPLY(a_diag_range, m_valid,
        m_m00 >= -ONE_Q14 && m_m00 <= ONE_Q14 && m_m22 >= -ONE_Q14 && m_m22 <= ONE_Q14,
        "diagonal entry out of range")
    `QRR_ASSERT(a_full_stall, (s_ready == 1'b0) |-> (v_reg == {STAGES{1'b1}} && !m_ready),
        "input stalled while the pipeline has room")

endmodule
`default_nettype wire
